@@ rtl/core/text_to_bcd_tape_record_encoder_top_macros.svh @@
// Assertion macros shared by the tape record encoder RTL.
// The macros refer to the i_clk and i_rst_n ports of the module that uses them.
`ifndef TEXT_TO_BCD_TAPE_RECORD_ENCODER_TOP_MACROS_SVH
`define TEXT_TO_BCD_TAPE_RECORD_ENCODER_TOP_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define TTBENC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ttbenc: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define TTBENC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ttbenc: implication violated");

`endif

@@ rtl/core/ttbenc_pkg.sv @@
// Package for the tape record encoder: types, codes and the BCD tables.
// No dependencies; used by the front end, the queue, the output stage and the top level.
package ttbenc_pkg;

    localparam int unsigned ColMax      = 65528;
    localparam int unsigned RecLenReset = 84;
    localparam int unsigned QueueDepth  = 4;
    localparam int unsigned QPtrW       = 2;

    localparam logic [7:0] ChTab = 8'h09;
    localparam logic [7:0] ChLf  = 8'h0A;
    localparam logic [7:0] ChFf  = 8'h0C;
    localparam logic [7:0] ChCr  = 8'h0D;

    localparam logic [7:0] TapeMark = 8'o217;
    localparam logic [7:0] RecMark  = 8'o200;
    localparam logic [5:0] BlankCode = 6'o60;

    localparam logic CmdChar = 1'b0;
    localparam logic CmdEnd  = 1'b1;

    // One queue entry: one or two results of a single transaction.
    typedef struct packed {
        logic [7:0] tape0;
        logic [7:0] rep0;
        logic       two;
        logic [7:0] tape1;
        logic [7:0] rep1;
    } t_job;

    typedef struct packed {
        logic [7:0] tape_byte;
        logic [7:0] repeat_count;
        logic       last;
    } t_res;

    // Character to 6-bit BCD code. Lower case folds onto upper case.
    function automatic logic [5:0] bcd_lookup(input logic [7:0] ch);
        logic [7:0] up;
        logic [5:0] code;
        up = ch;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            up = ch & 8'hDF;
        end
        code = BlankCode;
        case (up) inside
            8'h21: code = 6'o52;
            8'h24: code = 6'o53;
            8'h27: code = 6'o14;
            8'h28: code = 6'o74;
            8'h29: code = 6'o34;
            8'h2A: code = 6'o54;
            8'h2B: code = 6'o20;
            8'h2C: code = 6'o73;
            8'h2D: code = 6'o40;
            8'h2E: code = 6'o33;
            8'h2F: code = 6'o61;
            [8'h30:8'h39]: code = 6'(up - 8'h30);
            8'h3D: code = 6'o13;
            8'h3F: code = 6'o32;
            [8'h41:8'h49]: code = 6'(up - 8'h41 + 8'o21);
            [8'h4A:8'h52]: code = 6'(up - 8'h4A + 8'o41);
            [8'h53:8'h5A]: code = 6'(up - 8'h53 + 8'o62);
            default: code = BlankCode;
        endcase
        return code;
    endfunction

    // Tape form: zero becomes 012, bit 020 flips the zone bit, even parity at bit 6.
    function automatic logic [7:0] tape_form(input logic [5:0] code);
        logic [5:0] c;
        c = code;
        if (c == 6'o00) begin
            c = 6'o12;
        end else if (c[4]) begin
            c = c ^ 6'o40;
        end
        return {1'b0, ^c, c};
    endfunction

    localparam logic [7:0] BlankByte = tape_form(BlankCode);

endpackage

@@ rtl/core/ttbenc_if.sv @@
// Valid/ready channel interfaces for the tape record encoder.
// Fixed field widths; no package dependency.
interface ttbenc_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] char_code;

    modport source (output valid, command, char_code, input ready);
    modport sink   (input valid, command, char_code, output ready);
endinterface

interface ttbenc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tape_byte;
    logic [7:0] repeat_count;
    logic       last;

    modport source (output valid, tape_byte, repeat_count, last, input ready);
    modport sink   (input valid, tape_byte, repeat_count, last, output ready);
endinterface

@@ rtl/core/ttbenc_front.sv @@
// Front end: accepts characters, keeps the column count and builds queue entries.
// Depends on ttbenc_pkg, ttbenc_if and the assertion macro header.
`include "text_to_bcd_tape_record_encoder_top_macros.svh"

module ttbenc_front #(
    parameter int TAB_STOP   = 8,
    parameter int MAX_RECORD = 160
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    ttbenc_in_if.sink           i_in,
    input  logic                i_full,
    output logic                o_push,
    output ttbenc_pkg::t_job    o_job
);
    import ttbenc_pkg::*;

    localparam int PhaseW      = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int KW          = $clog2(TAB_STOP + 1);
    localparam int ColMaxPhase = ColMax % TAB_STOP;
    localparam int LenReset    = (RecLenReset > MAX_RECORD) ? MAX_RECORD : RecLenReset;

    logic [15:0]       r_col, n_col;
    logic [PhaseW-1:0] r_phase, n_phase;
    logic [7:0]        r_len, n_len;

    logic              accept;
    logic              at_zero;
    logic              col_lt_len;
    logic [7:0]        gap;
    logic [KW-1:0]     tab_k;
    logic [KW-1:0]     adv_n;
    logic [16:0]       adv_sum;
    logic [KW:0]       ph_sum;
    logic [15:0]       adv_col;
    logic [PhaseW-1:0] adv_phase;
    logic [7:0]        char_byte;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !i_full;
    assign at_zero    = (r_col == 16'd0);
    assign col_lt_len = (r_col < {8'd0, r_len});
    assign gap        = r_len - r_col[7:0];
    assign tab_k      = KW'(TAB_STOP) - KW'(r_phase);
    assign adv_n      = (i_in.char_code == ChTab) ? tab_k : KW'(1);
    assign char_byte  = tape_form(bcd_lookup(i_in.char_code)) | (at_zero ? RecMark : 8'd0);

    // Column advance with saturation; the tab phase tracks the column modulo the stop.
    always_comb begin
        adv_sum = {1'b0, r_col} + 17'(adv_n);
        ph_sum  = (KW+1)'(r_phase) + (KW+1)'(adv_n);
        if (adv_sum > 17'(ColMax)) begin
            adv_col   = 16'(ColMax);
            adv_phase = PhaseW'(ColMaxPhase);
        end else begin
            adv_col   = adv_sum[15:0];
            adv_phase = (ph_sum >= (KW+1)'(TAB_STOP)) ? PhaseW'(ph_sum - (KW+1)'(TAB_STOP))
                                                      : PhaseW'(ph_sum);
        end
    end

    always_comb begin
        n_col   = r_col;
        n_phase = r_phase;
        o_push  = 1'b0;
        o_job   = '0;
        n_len   = r_len;
        if (i_cfg_wr_en) begin
            n_len = ({1'b0, i_cfg_wr_data} > 9'(MAX_RECORD)) ? 8'(MAX_RECORD) : i_cfg_wr_data;
        end
        if (accept) begin
            if (i_in.command == CmdEnd) begin
                o_push = 1'b1;
                if (!at_zero && col_lt_len) begin
                    o_job = '{tape0: BlankByte, rep0: gap, two: 1'b1,
                              tape1: TapeMark, rep1: 8'd1};
                end else begin
                    o_job = '{tape0: TapeMark, rep0: 8'd1, two: 1'b0,
                              tape1: 8'd0, rep1: 8'd0};
                end
                n_col   = '0;
                n_phase = '0;
            end else begin
                case (i_in.char_code)
                    ChCr: begin
                    end
                    ChLf: begin
                        if (col_lt_len) begin
                            o_push = 1'b1;
                            if (at_zero) begin
                                o_job = '{tape0: BlankByte | RecMark, rep0: 8'd1,
                                          two: (r_len > 8'd1),
                                          tape1: BlankByte, rep1: r_len - 8'd1};
                            end else begin
                                o_job = '{tape0: BlankByte, rep0: gap, two: 1'b0,
                                          tape1: 8'd0, rep1: 8'd0};
                            end
                        end
                        n_col   = '0;
                        n_phase = '0;
                    end
                    ChFf: begin
                        o_push = 1'b1;
                        o_job  = '{tape0: TapeMark, rep0: 8'd1, two: 1'b0,
                                   tape1: 8'd0, rep1: 8'd0};
                    end
                    ChTab: begin
                        o_push = 1'b1;
                        if (at_zero) begin
                            o_job = '{tape0: BlankByte | RecMark, rep0: 8'd1,
                                      two: (tab_k > KW'(1)),
                                      tape1: BlankByte, rep1: 8'(tab_k - KW'(1))};
                        end else begin
                            o_job = '{tape0: BlankByte, rep0: 8'(tab_k), two: 1'b0,
                                      tape1: 8'd0, rep1: 8'd0};
                        end
                        n_col   = adv_col;
                        n_phase = adv_phase;
                    end
                    default: begin
                        o_push  = 1'b1;
                        o_job   = '{tape0: char_byte, rep0: 8'd1, two: 1'b0,
                                    tape1: 8'd0, rep1: 8'd0};
                        n_col   = adv_col;
                        n_phase = adv_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_phase <= '0;
            r_len   <= 8'(LenReset);
        end else begin
            r_col   <= n_col;
            r_phase <= n_phase;
            r_len   <= n_len;
        end
    end

    `TTBENC_ASSERT_ALWAYS(a_col_saturates, r_col <= 16'(ColMax))
    `TTBENC_ASSERT_IMPLY(a_phase_zero_at_start, r_col == 16'd0, r_phase == '0)

endmodule

@@ rtl/core/ttbenc_fifo.sv @@
// Short queue of result entries between the front end and the output stage.
// Depends on ttbenc_pkg and the assertion macro header.
`include "text_to_bcd_tape_record_encoder_top_macros.svh"

module ttbenc_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ttbenc_pkg::t_job i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output ttbenc_pkg::t_job o_job
);
    import ttbenc_pkg::*;

    t_job             r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPtrW:0]   r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (QPtrW+1)'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QPtrW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QPtrW'(1) : r_rd_ptr;
        n_count  = r_count + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `TTBENC_ASSERT_ALWAYS(a_count_bound, r_count <= (QPtrW+1)'(QueueDepth))
    `TTBENC_ASSERT_IMPLY(a_no_pop_empty, i_pop, !o_empty)

endmodule

@@ rtl/core/ttbenc_back.sv @@
// Output stage: splits queue entries into results and holds them in an output register.
// Depends on ttbenc_pkg, ttbenc_if and the assertion macro header.
`include "text_to_bcd_tape_record_encoder_top_macros.svh"

module ttbenc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  ttbenc_pkg::t_job i_job,
    output logic             o_pop,
    ttbenc_out_if.source     o_out
);
    import ttbenc_pkg::*;

    logic       r_valid, n_valid;
    logic       r_pend, n_pend;
    t_res       r_res, n_res;
    logic [7:0] r_sec_tape, n_sec_tape;
    logic [7:0] r_sec_rep, n_sec_rep;
    logic       can_load;

    // The register can take a new result when empty or when its result leaves now.
    assign can_load = !r_valid || o_out.ready;
    assign o_pop    = can_load && !r_pend && !i_empty;

    always_comb begin
        n_valid    = r_valid;
        n_pend     = r_pend;
        n_res      = r_res;
        n_sec_tape = r_sec_tape;
        n_sec_rep  = r_sec_rep;
        if (can_load) begin
            if (r_pend) begin
                n_res   = '{tape_byte: r_sec_tape, repeat_count: r_sec_rep, last: 1'b1};
                n_valid = 1'b1;
                n_pend  = 1'b0;
            end else if (!i_empty) begin
                n_res      = '{tape_byte: i_job.tape0, repeat_count: i_job.rep0,
                               last: !i_job.two};
                n_valid    = 1'b1;
                n_pend     = i_job.two;
                n_sec_tape = i_job.tape1;
                n_sec_rep  = i_job.rep1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_sec_tape <= n_sec_tape;
        r_sec_rep  <= n_sec_rep;
    end

    assign o_out.valid        = r_valid;
    assign o_out.tape_byte    = r_res.tape_byte;
    assign o_out.repeat_count = r_res.repeat_count;
    assign o_out.last         = r_res.last;

    `TTBENC_ASSERT_IMPLY(a_pend_needs_valid, r_pend, r_valid)
    `TTBENC_ASSERT_IMPLY(a_first_of_pair, r_valid && !r_res.last, r_pend)

endmodule

@@ rtl/core/text_to_bcd_tape_record_encoder_top.sv @@
// Text to 7-track BCD tape record encoder, top level.
// Input channel i_in carries a command (0 = character, 1 = end of input) and a
// character byte; output channel o_out carries tape_byte, repeat_count and last,
// where last marks the final result of an input transaction. Both channels are
// valid/ready. The record length register is written through i_cfg_wr_en and
// i_cfg_wr_data by the user, only while the block is idle, which the block does not
// enforce. Values above MAX_RECORD act as MAX_RECORD. Each accepted transaction yields
// zero, one or two results. One transaction is accepted per cycle, as i_in.ready falls
// only when the queue is full; a transaction with two results holds the output register
// for both, and a four-entry queue between the front end and the output stage absorbs
// the difference, so the output register sets the sustained rate at one result a cycle
// while the receiver is ready. When the receiver stalls, the output register holds its
// result and the queue fills. A synchronous active-low reset empties the queue, clears
// the column count and sets the record length to min(84, MAX_RECORD).
// Depends on ttbenc_pkg, ttbenc_if, ttbenc_front, ttbenc_fifo and ttbenc_back.

module text_to_bcd_tape_record_encoder_top #(
    parameter int TAB_STOP   = 8,
    parameter int MAX_RECORD = 160
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [7:0]    i_cfg_wr_data,
    ttbenc_in_if.sink     i_in,
    ttbenc_out_if.source  o_out
);
    import ttbenc_pkg::*;

    logic full;
    logic empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_out;

    ttbenc_front #(
        .TAB_STOP   (TAB_STOP),
        .MAX_RECORD (MAX_RECORD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_full        (full),
        .o_push        (push),
        .o_job         (job_in)
    );

    ttbenc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_job   (job_out)
    );

    ttbenc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
